// ----- sv/wtg_pkg.sv -----
// Shared types, codes and constants of the waypoint and target guidance block.
`default_nettype none
package wtg_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int SPEED_WIDTH    = 16;
   localparam int RADIUS_WIDTH   = 23;
   localparam int LAP_WIDTH      = 8;
   localparam int WPCOUNT_WIDTH  = 5;
   localparam int AGE_WIDTH      = 16;
   localparam int SLOT_WIDTH     = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_APPROACH_SPEED    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEPTANCE_RADIUS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOITER_ALTITUDE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAYPOINT_RADIUS   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAP_TOTAL         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAYPOINT_COUNT    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STALE_LIMIT       = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TARGET_DIST   = 3'd7;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_POSITION = 2'd1;
   localparam logic [1:0] KIND_TARGET   = 2'd2;
   localparam logic [1:0] KIND_WAYPOINT = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [1:0]            kind;
      coord_type             coord_x;
      coord_type             coord_y;
      coord_type             coord_z;
      logic [SLOT_WIDTH-1:0] entry_index;
   } req_type;

   typedef struct packed {
      coord_type      set_x;
      coord_type      set_y;
      coord_type      set_z;
      logic [2:0]     mode;
      logic [3:0]     cursor;
      logic [7:0]     laps_finished;
      logic           low_altitude;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_NO_POSITION = 3'd0,
      MODE_TGT_APPROACH = 3'd1,
      MODE_TGT_HOLD     = 3'd2,
      MODE_WAYPOINT     = 3'd3,
      MODE_LAPS_DONE    = 3'd4,
      MODE_IDLE_HOLD    = 3'd5
   } mode_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_DIFF_TGT,
      OP_DIFF_WP,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_Z,
      OP_SUM3,
      OP_THR_ACC,
      OP_SEL_D3,
      OP_FIX_CURSOR,
      OP_READ_WP,
      OP_ADVANCE,
      OP_SPEED_SQ,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_MUL_X,
      OP_MUL_Y,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_OFF_X,
      OP_RES_ORIGIN,
      OP_RES_VEH,
      OP_RES_GOAL,
      OP_RES_STEP,
      OP_LOAD_OUT
   } op_type;

   typedef enum logic {
      THR_MAX_DIST,
      THR_WP_RADIUS
   } thr_sel_type;

   typedef struct packed {
      op_type      op;
      thr_sel_type thr;
      logic        z_goal;
      mode_type    mode;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic pos_seen;
      logic tgt_valid;
      logic h2_below;
      logic wp_active;
      logic laps_left;
      logic speed_covers;
      logic sqrt_done;
      logic div_done;
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ORIGIN,
      S_T_DIFF,
      S_SQ_X,
      S_SQ_Y,
      S_SQ_Z,
      S_SUM3,
      S_T_CHK,
      S_T_HOLD,
      S_W_START,
      S_W_RD,
      S_W_DIFF,
      S_W_ADV,
      S_W_CHK,
      S_G_SEL,
      S_ST_SPD,
      S_ST_CMP,
      S_SQRT,
      S_DIVX_INIT,
      S_DIVX,
      S_MULY,
      S_DIVY_INIT,
      S_DIVY,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_TARGET,
      PH_REACH,
      PH_GO
   } phase_type;

endpackage
`default_nettype wire

// ----- sv/wtg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wtg_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_WIDTH-1:0] waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [ADDR_WIDTH-1:0] raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- sv/wtg_datapath.sv -----
// Datapath: guidance state, waypoint table, shared multiplier, square root and divider.
`default_nettype none
module wtg_datapath #(
   parameter int WAYPOINT_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wtg_pkg::req_type                    req_payload,
   input  logic                                csr_we,
   input  logic [wtg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wtg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wtg_pkg::cmd_type                    cmd,
   output wtg_pkg::status_type                 status,
   output wtg_pkg::rsp_type                    rsp_payload
);
   import wtg_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int PW    = 2 * CW;
   localparam int SW    = PW + 2;
   localparam int RW    = SW / 2;
   localparam int NW    = PW + 1;
   localparam int DCW   = $clog2(NW + 1);
   localparam int AW    = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
   localparam int CUR_W = WPCOUNT_WIDTH;
   localparam int CNT_W = ($clog2(WAYPOINT_DEPTH + 1) > CUR_W) ?
                          $clog2(WAYPOINT_DEPTH + 1) : CUR_W;
   localparam int XW    = (AW > CUR_W) ? AW : CUR_W;
   localparam int EW    = (AW > SLOT_WIDTH) ? AW : SLOT_WIDTH;
   localparam logic signed [CW+1:0] CMAX = (CW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [CW+1:0] CMIN = -CMAX - (CW+2)'(1);
   localparam logic signed [CW-1:0] LOW_BOUND = -(CW'(512));

   function automatic logic [CW-1:0] mag_of(input logic signed [CW:0] d);
      logic [CW:0] n;
      n = d[CW] ? -d : d;
      return n[CW-1:0];
   endfunction

   function automatic coord_type step_axis(input coord_type base, input logic neg,
                                           input logic [CW:0] off);
      logic signed [CW+1:0] sum;
      sum = (CW+2)'(base) + (neg ? -$signed({1'b0, off}) : $signed({1'b0, off}));
      if (sum > CMAX) begin
         return CMAX[CW-1:0];
      end else if (sum < CMIN) begin
         return CMIN[CW-1:0];
      end
      return sum[CW-1:0];
   endfunction

   // configuration
   logic [SPEED_WIDTH-1:0]   speed_ff;
   logic [RADIUS_WIDTH-1:0]  acc_rad_ff;
   coord_type                loiter_ff;
   logic [RADIUS_WIDTH-1:0]  wp_rad_ff;
   logic [LAP_WIDTH-1:0]     lap_total_ff;
   logic [WPCOUNT_WIDTH-1:0] wp_count_ff;
   logic [AGE_WIDTH-1:0]     stale_ff;
   logic [RADIUS_WIDTH-1:0]  max_dist_ff;

   // control state
   logic                 pos_seen_ff;
   logic                 tgt_seen_ff;
   logic [AGE_WIDTH-1:0] age_ff;
   logic [CUR_W-1:0]     cursor_ff;
   logic [LAP_WIDTH-1:0] laps_ff;
   logic [SW-1:0]        sq_bit_ff;
   logic [DCW-1:0]       div_cnt_ff;

   // payload
   coord_type              veh_ff [3];
   coord_type              tgt_ff [3];
   coord_type              goal_ff [3];
   logic signed [CW:0]     diff_ff [3];
   logic [PW-1:0]          prod_ff;
   logic [SW-1:0]          acc_ff;
   logic [SW-1:0]          h2_ff;
   logic [SW-1:0]          d3_ff;
   logic [SW-1:0]          d_ff;
   logic [SW-1:0]          sq_rem_ff;
   logic [SW-1:0]          sq_root_ff;
   logic [NW-1:0]          num_ff;
   logic [RW:0]            drem_ff;
   logic [CW:0]            offx_ff;
   coord_type              res_x_ff, res_y_ff, res_z_ff;
   mode_type               res_mode_ff;
   rsp_type                out_ff;

   logic                   is_accept;
   logic [CNT_W-1:0]       count_c;
   logic [CNT_W-1:0]       cursor_x;
   logic [CNT_W-1:0]       cursor_p1;
   logic [CW-1:0]          mul_a, mul_b;
   logic [PW-1:0]          mul_p;
   logic [SW:0]            trial;
   logic                   take;
   logic [RW-1:0]          dist_val;
   logic [RW:0]            den;
   logic [RW+1:0]          r2;
   logic [RW+1:0]          r2_next;
   logic                   ge;
   logic [3*CW-1:0]        ram_wdata;
   logic [3*CW-1:0]        ram_rdata;
   logic                   ram_we;
   logic [EW-1:0]          slot_x;
   logic [XW-1:0]          cur_addr_x;
   logic                   slot_ok;
   coord_type              wp_c [3];
   coord_type              zsel;
   logic [RADIUS_WIDTH-1:0] thr_val;

   assign is_accept = (cmd.op == OP_ACCEPT);
   assign count_c   = (CNT_W'(wp_count_ff) > CNT_W'(WAYPOINT_DEPTH)) ?
                      CNT_W'(WAYPOINT_DEPTH) : CNT_W'(wp_count_ff);
   assign cursor_x  = CNT_W'(cursor_ff);
   assign cursor_p1 = cursor_x + CNT_W'(1);

   // waypoint table
   assign slot_ok    = CNT_W'(req_payload.entry_index) < CNT_W'(WAYPOINT_DEPTH);
   assign ram_we     = is_accept && (req_payload.kind == KIND_WAYPOINT) && slot_ok;
   assign slot_x     = EW'(req_payload.entry_index);
   assign cur_addr_x = XW'(cursor_ff);
   assign ram_wdata  = {req_payload.coord_x, req_payload.coord_y, req_payload.coord_z};

   wtg_ram #(
      .WIDTH(3 * CW),
      .DEPTH(WAYPOINT_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(slot_x[AW-1:0]),
      .wdata(ram_wdata),
      .re   (cmd.op == OP_READ_WP),
      .raddr(cur_addr_x[AW-1:0]),
      .rdata(ram_rdata)
   );

   assign wp_c[0] = ram_rdata[3*CW-1 -: CW];
   assign wp_c[1] = ram_rdata[2*CW-1 -: CW];
   assign wp_c[2] = ram_rdata[CW-1:0];

   // shared multiplier
   assign thr_val = (cmd.thr == THR_MAX_DIST) ? max_dist_ff : wp_rad_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SQ_X: begin
            mul_a = mag_of(diff_ff[0]);
            mul_b = mag_of(diff_ff[0]);
         end
         OP_SQ_Y: begin
            mul_a = mag_of(diff_ff[1]);
            mul_b = mag_of(diff_ff[1]);
         end
         OP_SQ_Z: begin
            mul_a = mag_of(diff_ff[2]);
            mul_b = mag_of(diff_ff[2]);
         end
         OP_SUM3: begin
            mul_a = CW'(thr_val);
            mul_b = CW'(thr_val);
         end
         OP_THR_ACC: begin
            mul_a = CW'(acc_rad_ff);
            mul_b = CW'(acc_rad_ff);
         end
         OP_SPEED_SQ: begin
            mul_a = CW'(speed_ff);
            mul_b = CW'(speed_ff);
         end
         OP_MUL_X: begin
            mul_a = mag_of(diff_ff[0]);
            mul_b = CW'(speed_ff);
         end
         OP_MUL_Y: begin
            mul_a = mag_of(diff_ff[1]);
            mul_b = CW'(speed_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // square root and divider steps
   assign trial    = {1'b0, sq_root_ff} + {1'b0, sq_bit_ff};
   assign take     = {1'b0, sq_rem_ff} >= trial;
   assign dist_val = (sq_root_ff == '0) ? RW'(1) : sq_root_ff[RW-1:0];
   assign den      = {dist_val, 1'b0};
   assign r2       = {drem_ff, num_ff[NW-1]};
   assign ge       = r2 >= {1'b0, den};
   assign r2_next  = ge ? (r2 - {1'b0, den}) : r2;
   assign zsel     = cmd.z_goal ? goal_ff[2] : loiter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= SPEED_WIDTH'(512);
         acc_rad_ff   <= RADIUS_WIDTH'(256);
         loiter_ff    <= -(CW'(2560));
         wp_rad_ff    <= RADIUS_WIDTH'(7680);
         lap_total_ff <= LAP_WIDTH'(1);
         wp_count_ff  <= '0;
         stale_ff     <= AGE_WIDTH'(40);
         max_dist_ff  <= RADIUS_WIDTH'(128000);
         pos_seen_ff  <= 1'b0;
         tgt_seen_ff  <= 1'b0;
         age_ff       <= '0;
         cursor_ff    <= '0;
         laps_ff      <= '0;
         sq_bit_ff    <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_APPROACH_SPEED:    speed_ff     <= csr_wdata[SPEED_WIDTH-1:0];
               CSR_ACCEPTANCE_RADIUS: acc_rad_ff   <= csr_wdata[RADIUS_WIDTH-1:0];
               CSR_LOITER_ALTITUDE:   loiter_ff    <= coord_type'(csr_wdata[CW-1:0]);
               CSR_WAYPOINT_RADIUS:   wp_rad_ff    <= csr_wdata[RADIUS_WIDTH-1:0];
               CSR_LAP_TOTAL:         lap_total_ff <= csr_wdata[LAP_WIDTH-1:0];
               CSR_WAYPOINT_COUNT:    wp_count_ff  <= csr_wdata[WPCOUNT_WIDTH-1:0];
               CSR_STALE_LIMIT:       stale_ff     <= csr_wdata[AGE_WIDTH-1:0];
               CSR_MAX_TARGET_DIST:   max_dist_ff  <= csr_wdata[RADIUS_WIDTH-1:0];
               default: ;
            endcase
         end
         unique case (cmd.op)
            OP_ACCEPT: begin
               unique case (req_payload.kind)
                  KIND_POSITION: pos_seen_ff <= 1'b1;
                  KIND_TARGET: begin
                     tgt_seen_ff <= 1'b1;
                     age_ff      <= '0;
                  end
                  KIND_TICK: begin
                     if (age_ff != '1) begin
                        age_ff <= age_ff + AGE_WIDTH'(1);
                     end
                  end
                  default: ;
               endcase
            end
            OP_FIX_CURSOR: begin
               if (cursor_x >= count_c) begin
                  cursor_ff <= '0;
               end
            end
            OP_ADVANCE: begin
               if (status.h2_below) begin
                  if (cursor_p1 >= count_c) begin
                     cursor_ff <= '0;
                     laps_ff   <= laps_ff + LAP_WIDTH'(1);
                  end else begin
                     cursor_ff <= cursor_p1[CUR_W-1:0];
                  end
               end
            end
            OP_SQRT_INIT: sq_bit_ff <= SW'(1) << (SW - 2);
            OP_SQRT_STEP: sq_bit_ff <= sq_bit_ff >> 2;
            OP_DIV_INIT:  div_cnt_ff <= DCW'(NW);
            OP_DIV_STEP:  div_cnt_ff <= div_cnt_ff - DCW'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            if (req_payload.kind == KIND_POSITION) begin
               veh_ff[0] <= req_payload.coord_x;
               veh_ff[1] <= req_payload.coord_y;
               veh_ff[2] <= req_payload.coord_z;
            end
            if (req_payload.kind == KIND_TARGET) begin
               tgt_ff[0] <= req_payload.coord_x;
               tgt_ff[1] <= req_payload.coord_y;
               tgt_ff[2] <= req_payload.coord_z;
            end
         end
         OP_DIFF_TGT: begin
            for (int i = 0; i < 3; i++) begin
               goal_ff[i] <= tgt_ff[i];
               diff_ff[i] <= (CW+1)'(tgt_ff[i]) - (CW+1)'(veh_ff[i]);
            end
         end
         OP_DIFF_WP: begin
            for (int i = 0; i < 3; i++) begin
               goal_ff[i] <= wp_c[i];
               diff_ff[i] <= (CW+1)'(wp_c[i]) - (CW+1)'(veh_ff[i]);
            end
         end
         OP_SQ_X: prod_ff <= mul_p;
         OP_SQ_Y: begin
            acc_ff  <= SW'(prod_ff);
            prod_ff <= mul_p;
         end
         OP_SQ_Z: begin
            acc_ff  <= acc_ff + SW'(prod_ff);
            prod_ff <= mul_p;
         end
         OP_SUM3: begin
            h2_ff   <= acc_ff;
            d3_ff   <= acc_ff + SW'(prod_ff);
            prod_ff <= mul_p;
         end
         OP_THR_ACC: begin
            prod_ff <= mul_p;
            d_ff    <= h2_ff;
         end
         OP_SEL_D3:   d_ff <= d3_ff;
         OP_SPEED_SQ: prod_ff <= mul_p;
         OP_MUL_X:    prod_ff <= mul_p;
         OP_MUL_Y:    prod_ff <= mul_p;
         OP_SQRT_INIT: begin
            sq_rem_ff  <= d_ff;
            sq_root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            if (take) begin
               sq_rem_ff  <= sq_rem_ff - trial[SW-1:0];
               sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_ff <= sq_root_ff >> 1;
            end
         end
         OP_DIV_INIT: begin
            num_ff  <= NW'(prod_ff) + NW'(dist_val);
            drem_ff <= '0;
         end
         OP_DIV_STEP: begin
            drem_ff <= r2_next[RW:0];
            num_ff  <= {num_ff[NW-2:0], ge};
         end
         OP_OFF_X: offx_ff <= num_ff[CW:0];
         OP_RES_ORIGIN: begin
            res_x_ff    <= '0;
            res_y_ff    <= '0;
            res_z_ff    <= loiter_ff;
            res_mode_ff <= cmd.mode;
         end
         OP_RES_VEH: begin
            res_x_ff    <= veh_ff[0];
            res_y_ff    <= veh_ff[1];
            res_z_ff    <= loiter_ff;
            res_mode_ff <= cmd.mode;
         end
         OP_RES_GOAL: begin
            res_x_ff    <= goal_ff[0];
            res_y_ff    <= goal_ff[1];
            res_z_ff    <= zsel;
            res_mode_ff <= cmd.mode;
         end
         OP_RES_STEP: begin
            res_x_ff    <= step_axis(veh_ff[0], diff_ff[0][CW], offx_ff);
            res_y_ff    <= step_axis(veh_ff[1], diff_ff[1][CW], num_ff[CW:0]);
            res_z_ff    <= zsel;
            res_mode_ff <= cmd.mode;
         end
         OP_LOAD_OUT: begin
            out_ff.set_x         <= res_x_ff;
            out_ff.set_y         <= res_y_ff;
            out_ff.set_z         <= res_z_ff;
            out_ff.mode          <= res_mode_ff;
            out_ff.cursor        <= cursor_ff[3:0];
            out_ff.laps_finished <= laps_ff;
            out_ff.low_altitude  <= pos_seen_ff && (veh_ff[2] > LOW_BOUND) &&
                                    (veh_ff[2] < 0);
         end
         default: ;
      endcase
   end

   always_comb begin
      status.is_tick      = (req_payload.kind == KIND_TICK);
      status.pos_seen     = pos_seen_ff;
      status.tgt_valid    = tgt_seen_ff && (age_ff <= stale_ff) &&
                            !(d3_ff > SW'(prod_ff));
      status.h2_below     = h2_ff < SW'(prod_ff);
      status.laps_left    = laps_ff < lap_total_ff;
      status.wp_active    = (wp_count_ff != '0) && (laps_ff < lap_total_ff);
      status.speed_covers = (SW+2)'(prod_ff) >= {d_ff, 2'b00};
      status.sqrt_done    = (sq_bit_ff == '0);
      status.div_done     = (div_cnt_ff == '0);
   end

   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

// ----- sv/wtg_ctrl.sv -----
// Controller: sequences the datapath through one tick and runs both handshakes.
`default_nettype none
module wtg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  wtg_pkg::status_type status,
   output wtg_pkg::cmd_type    cmd
);
   import wtg_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_TARGET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && status.is_tick) begin
               phase_in = PH_TARGET;
               state_in = status.pos_seen ? S_T_DIFF : S_ORIGIN;
            end
         end
         S_ORIGIN: state_in = S_FINISH;
         S_T_DIFF: state_in = S_SQ_X;
         S_SQ_X:   state_in = S_SQ_Y;
         S_SQ_Y:   state_in = S_SQ_Z;
         S_SQ_Z:   state_in = S_SUM3;
         S_SUM3: begin
            unique case (phase_ff)
               PH_TARGET: state_in = S_T_CHK;
               PH_REACH:  state_in = S_W_ADV;
               default:   state_in = S_G_SEL;
            endcase
         end
         S_T_CHK:  state_in = status.tgt_valid ? S_T_HOLD : S_W_START;
         S_T_HOLD: state_in = status.h2_below ? S_FINISH : S_ST_SPD;
         S_W_START: begin
            if (status.wp_active) begin
               phase_in = PH_REACH;
               state_in = S_W_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_W_RD:   state_in = S_W_DIFF;
         S_W_DIFF: state_in = S_SQ_X;
         S_W_ADV:  state_in = S_W_CHK;
         S_W_CHK: begin
            if (status.laps_left) begin
               phase_in = PH_GO;
               state_in = S_W_DIFF;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_G_SEL:     state_in = S_ST_SPD;
         S_ST_SPD:    state_in = S_ST_CMP;
         S_ST_CMP:    state_in = status.speed_covers ? S_FINISH : S_SQRT;
         S_SQRT:      state_in = status.sqrt_done ? S_DIVX_INIT : S_SQRT;
         S_DIVX_INIT: state_in = S_DIVX;
         S_DIVX:      state_in = status.div_done ? S_MULY : S_DIVX;
         S_MULY:      state_in = S_DIVY_INIT;
         S_DIVY_INIT: state_in = S_DIVY;
         S_DIVY:      state_in = status.div_done ? S_FINISH : S_DIVY;
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = OP_NOP;
      cmd.thr    = (phase_ff == PH_TARGET) ? THR_MAX_DIST : THR_WP_RADIUS;
      cmd.z_goal = (phase_ff != PH_TARGET);
      cmd.mode   = (phase_ff == PH_TARGET) ? MODE_TGT_APPROACH : MODE_WAYPOINT;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? OP_ACCEPT : OP_NOP;
         S_ORIGIN: begin
            cmd.op   = OP_RES_ORIGIN;
            cmd.mode = MODE_NO_POSITION;
         end
         S_T_DIFF: cmd.op = OP_DIFF_TGT;
         S_SQ_X:   cmd.op = OP_SQ_X;
         S_SQ_Y:   cmd.op = OP_SQ_Y;
         S_SQ_Z:   cmd.op = OP_SQ_Z;
         S_SUM3:   cmd.op = OP_SUM3;
         S_T_CHK:  cmd.op = status.tgt_valid ? OP_THR_ACC : OP_NOP;
         S_T_HOLD: begin
            if (status.h2_below) begin
               cmd.op   = OP_RES_GOAL;
               cmd.mode = MODE_TGT_HOLD;
            end
         end
         S_W_START: begin
            if (status.wp_active) begin
               cmd.op = OP_FIX_CURSOR;
            end else begin
               cmd.op     = OP_RES_VEH;
               cmd.mode   = MODE_IDLE_HOLD;
            end
         end
         S_W_RD:   cmd.op = OP_READ_WP;
         S_W_DIFF: cmd.op = OP_DIFF_WP;
         S_W_ADV:  cmd.op = OP_ADVANCE;
         S_W_CHK: begin
            if (status.laps_left) begin
               cmd.op = OP_READ_WP;
            end else begin
               cmd.op   = OP_RES_VEH;
               cmd.mode = MODE_LAPS_DONE;
            end
         end
         S_G_SEL:     cmd.op = OP_SEL_D3;
         S_ST_SPD:    cmd.op = OP_SPEED_SQ;
         S_ST_CMP:    cmd.op = status.speed_covers ? OP_RES_GOAL : OP_SQRT_INIT;
         S_SQRT:      cmd.op = status.sqrt_done ? OP_MUL_X : OP_SQRT_STEP;
         S_DIVX_INIT: cmd.op = OP_DIV_INIT;
         S_DIVX:      cmd.op = status.div_done ? OP_OFF_X : OP_DIV_STEP;
         S_MULY:      cmd.op = OP_MUL_Y;
         S_DIVY_INIT: cmd.op = OP_DIV_INIT;
         S_DIVY:      cmd.op = status.div_done ? OP_RES_STEP : OP_DIV_STEP;
         S_FINISH:    cmd.op = out_free ? OP_LOAD_OUT : OP_NOP;
         default:     cmd.op = OP_NOP;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/waypoint_target_guidance_top.sv -----
// Top level of the waypoint and target guidance setpoint generator.
// Items on the req_ channel are ticks, vehicle positions, target positions
// and waypoint writes, coordinates NED in 1/256 m. Position, target and
// waypoint items are taken in the idle state and give no result. Each tick
// gives exactly one setpoint item on the rsp_ channel: the origin at loiter
// altitude before any position, else a fresh target within the distance
// limit first, then the waypoint laps, else a hold. A step toward a target
// or a waypoint uses the square root (25 steps and a final check) and
// two bit-serial divisions (49 steps and a final check each); the squares
// and products share one multiplier in the datapath.
// Non-tick items are taken while a finished setpoint still waits on rsp_;
// a tick then waits at its last step until the output register is free.
// The user must write configuration through csr_ only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module waypoint_target_guidance_top #(
   parameter int WAYPOINT_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wtg_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wtg_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [wtg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wtg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import wtg_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequence each tick; hold input while busy
   wtg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // keep guidance state, table and arithmetic units
   wtg_datapath #(
      .WAYPOINT_DEPTH(WAYPOINT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

// ----- tb/tb_waypoint_target_guidance_top.sv -----
// Self-checking testbench for the waypoint and target guidance setpoint generator.
`default_nettype none
module tb_waypoint_target_guidance_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wtg_pkg::*;

   localparam int WP_DEPTH   = 16;
   localparam int STALL_MAX  = 400;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 300;
   localparam longint CMAXV  = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint CMINV  = -CMAXV - 1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   always #1 clock = ~clock;

   waypoint_target_guidance_top #(.WAYPOINT_DEPTH(WP_DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Guidance state mirrored by the predictor.
   longint speed, acc_rad, loiter, wp_rad, lap_goal, wp_count, stale, max_dist;
   longint veh [3];
   longint tgt [3];
   longint wp_table [WP_DEPTH][3];
   bit     wp_written [WP_DEPTH];
   bit     have_pos, have_tgt;
   longint tgt_age, cursor_q, laps_q;

   rsp_type setpoint_q[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   bit      hold_rsp = 1'b0;

   function automatic longint sqr(longint d);
      return d * d;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > CMAXV) return CMAXV;
      if (v < CMINV) return CMINV;
      return v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Step horizontally from the vehicle toward gx/gy; d2 is squared distance.
   task automatic step_to(input longint gx, input longint gy, input longint d2,
                          output longint ox, output longint oy);
      longint hdist, d, mag, off;
      longint g [2];
      longint r [2];
      g[0] = gx;
      g[1] = gy;
      if (speed * speed >= 4 * d2) begin
         ox = gx;
         oy = gy;
         return;
      end
      hdist = int_sqrt(d2);
      if (hdist == 0) hdist = 1;
      for (int a = 0; a < 2; a++) begin
         d = g[a] - veh[a];
         mag = (d < 0) ? -d : d;
         off = (mag * speed + hdist) / (2 * hdist);
         r[a] = clamp_coord(veh[a] + ((d < 0) ? -off : off));
      end
      ox = r[0];
      oy = r[1];
   endtask

   // Update the mirrored state for one item and queue the setpoint it causes.
   task automatic predict_setpoint(input req_type it);
      longint c [3];
      longint sx, sy, sz, h2, cnt, d2;
      logic [2:0] md;
      bit ok, lo;
      rsp_type r;
      c[0] = it.coord_x;
      c[1] = it.coord_y;
      c[2] = it.coord_z;
      case (it.kind)
         KIND_POSITION: begin
            veh = c;
            have_pos = 1'b1;
            return;
         end
         KIND_TARGET: begin
            tgt = c;
            have_tgt = 1'b1;
            tgt_age = 0;
            return;
         end
         KIND_WAYPOINT: begin
            wp_table[it.entry_index] = c;
            wp_written[it.entry_index] = 1'b1;
            return;
         end
         default: ;
      endcase
      if (tgt_age < 65535) tgt_age++;
      cnt = (wp_count > WP_DEPTH) ? WP_DEPTH : wp_count;
      lo = 1'b0;
      if (!have_pos) begin
         sx = 0; sy = 0; sz = loiter; md = MODE_NO_POSITION;
      end else begin
         ok = have_tgt && tgt_age <= stale;
         h2 = sqr(tgt[0] - veh[0]) + sqr(tgt[1] - veh[1]);
         if (ok && h2 + sqr(tgt[2] - veh[2]) > max_dist * max_dist) ok = 1'b0;
         if (ok) begin
            sz = loiter;
            if (h2 < acc_rad * acc_rad) begin
               sx = tgt[0]; sy = tgt[1]; md = MODE_TGT_HOLD;
            end else begin
               step_to(tgt[0], tgt[1], h2, sx, sy);
               md = MODE_TGT_APPROACH;
            end
         end else if (cnt > 0 && laps_q < lap_goal) begin
            if (cursor_q >= cnt) cursor_q = 0;
            if (sqr(wp_table[cursor_q][0] - veh[0]) + sqr(wp_table[cursor_q][1] - veh[1])
                < wp_rad * wp_rad) begin
               cursor_q++;
               if (cursor_q >= cnt) begin
                  cursor_q = 0;
                  laps_q++;
               end
            end
            if (laps_q < lap_goal) begin
               d2 = sqr(wp_table[cursor_q][0] - veh[0]) + sqr(wp_table[cursor_q][1] - veh[1])
                  + sqr(wp_table[cursor_q][2] - veh[2]);
               step_to(wp_table[cursor_q][0], wp_table[cursor_q][1], d2, sx, sy);
               sz = wp_table[cursor_q][2];
               md = MODE_WAYPOINT;
            end else begin
               sx = veh[0]; sy = veh[1]; sz = loiter; md = MODE_LAPS_DONE;
            end
         end else begin
            sx = veh[0]; sy = veh[1]; sz = loiter; md = MODE_IDLE_HOLD;
         end
         lo = veh[2] > -512 && veh[2] < 0;
      end
      r.set_x = sx[COORD_WIDTH-1:0];
      r.set_y = sy[COORD_WIDTH-1:0];
      r.set_z = sz[COORD_WIDTH-1:0];
      r.mode = md;
      r.cursor = cursor_q[3:0];
      r.laps_finished = laps_q[7:0];
      r.low_altitude = lo;
      setpoint_q = {setpoint_q, r};
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_APPROACH_SPEED:    speed = value & 64'hFFFF;
         CSR_ACCEPTANCE_RADIUS: acc_rad = value & 64'h7FFFFF;
         CSR_LOITER_ALTITUDE:   loiter = longint'(signed'(value[23:0]));
         CSR_WAYPOINT_RADIUS:   wp_rad = value & 64'h7FFFFF;
         CSR_LAP_TOTAL:         lap_goal = value & 64'hFF;
         CSR_WAYPOINT_COUNT:    wp_count = value & 64'h1F;
         CSR_STALE_LIMIT:       stale = value & 64'hFFFF;
         default:               max_dist = value & 64'h7FFFFF;
      endcase
   endtask

   // No gap half the time, else mostly short gaps and a long one now and then.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Present one item and hold it until it is taken; valid stays high after
   // the take and is dropped by the next gap or by wait_idle.
   task automatic send_item(input req_type it);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_setpoint(it);
   endtask

   // Drop the input, drain, then let the block settle before touching registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic req_type mk(input logic [1:0] k, input longint x, input longint y,
                                  input longint z, input int slot);
      req_type it;
      it.kind = k;
      it.coord_x = x[COORD_WIDTH-1:0];
      it.coord_y = y[COORD_WIDTH-1:0];
      it.coord_z = z[COORD_WIDTH-1:0];
      it.entry_index = slot[3:0];
      return it;
   endfunction

   function automatic longint rnd_coord(input longint span);
      if ($urandom_range(0, 9) == 0)
         return longint'(signed'(24'($urandom())));
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Receiver side: random stalls, compare each setpoint with the oldest one queued.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (hold_rsp) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 99) < 25) ||
                           ($urandom_range(0, 199) == 0 && rsp_stall);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (setpoint_q.size() == 0) begin
               $error("setpoint with none expected: %p", rsp_payload);
               fail_count++;
            end else begin
               want = setpoint_q.pop_front();
               if (rsp_payload.set_x !== want.set_x) begin
                  $error("set_x expected %0d got %0d", want.set_x, rsp_payload.set_x);
                  fail_count++;
               end
               if (rsp_payload.set_y !== want.set_y) begin
                  $error("set_y expected %0d got %0d", want.set_y, rsp_payload.set_y);
                  fail_count++;
               end
               if (rsp_payload.set_z !== want.set_z) begin
                  $error("set_z expected %0d got %0d", want.set_z, rsp_payload.set_z);
                  fail_count++;
               end
               if (rsp_payload.mode !== want.mode) begin
                  $error("mode expected %0d got %0d", want.mode, rsp_payload.mode);
                  fail_count++;
               end
               if (rsp_payload.cursor !== want.cursor) begin
                  $error("cursor expected %0d got %0d", want.cursor, rsp_payload.cursor);
                  fail_count++;
               end
               if (rsp_payload.laps_finished !== want.laps_finished) begin
                  $error("laps_finished expected %0d got %0d", want.laps_finished,
                         rsp_payload.laps_finished);
                  fail_count++;
               end
               if (rsp_payload.low_altitude !== want.low_altitude) begin
                  $error("low_altitude expected %0d got %0d", want.low_altitude,
                         rsp_payload.low_altitude);
                  fail_count++;
               end
            end
         end
      end
   end

   // Directed rows: kind, coordinates, slot.
   typedef struct {
      logic [1:0] k;
      longint     x, y, z;
      int         slot;
   } row_type;

   row_type rows [$];
   row_type rw;
   req_type it;
   rsp_type typed;
   int      n_wp, kind_pick;
   longint  span;

   initial begin
      speed = 512; acc_rad = 256; loiter = -2560; wp_rad = 7680;
      lap_goal = 1; wp_count = 0; stale = 40; max_dist = 128000;
      veh = '{0, 0, 0}; tgt = '{0, 0, 0};
      have_pos = 0; have_tgt = 0; tgt_age = 0; cursor_q = 0; laps_q = 0;
      foreach (wp_written[i]) wp_written[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Tick before any position: origin at reset loiter altitude, checked by hand.
      send_item(mk(KIND_TICK, 0, 0, 0, 0));
      typed = '0;
      typed.set_z = -24'sd2560;
      typed.mode = MODE_NO_POSITION;
      if (setpoint_q[setpoint_q.size() - 1] !== typed) begin
         $error("setpoint expected %p got %p", typed, setpoint_q[setpoint_q.size() - 1]);
         fail_count++;
      end

      // Walk the directed table: extremes, every kind, hold and approach, low altitude.
      rows = '{
         '{KIND_POSITION, CMAXV, CMINV, -1, 0},
         '{KIND_TICK, 0, 0, 0, 0},
         '{KIND_POSITION, 0, 0, -511, 0},
         '{KIND_TARGET, 100, 50, 0, 0},
         '{KIND_TICK, 0, 0, 0, 0},
         '{KIND_TARGET, 20000, -30000, -2000, 0},
         '{KIND_TICK, 0, 0, 0, 0},
         '{KIND_POSITION, CMINV, CMAXV, -512, 0},
         '{KIND_TARGET, CMINV + 5000, CMAXV - 5000, -512, 0},
         '{KIND_TICK, 0, 0, 0, 0},
         '{KIND_TARGET, CMAXV, CMINV, CMAXV, 0},
         '{KIND_TICK, 0, 0, 0, 0},
         '{KIND_WAYPOINT, 3000, 3000, -2560, 0},
         '{KIND_WAYPOINT, -40000, 9000, -5000, 1},
         '{KIND_WAYPOINT, CMAXV, CMINV, CMINV, 15},
         '{KIND_POSITION, 0, 0, 0, 0},
         '{KIND_TICK, 0, 0, 0, 0}
      };
      foreach (rows[i]) begin
         rw = rows[i];
         send_item(mk(rw.k, rw.x, rw.y, rw.z, rw.slot));
      end
      wait_idle();

      // Waypoint laps over slots 0..1 with a stale target and zero speed, then a fresh target at full speed.
      write_reg(CSR_WAYPOINT_COUNT, 2);
      write_reg(CSR_LAP_TOTAL, 2);
      write_reg(CSR_STALE_LIMIT, 0);
      write_reg(CSR_APPROACH_SPEED, 0);
      for (int i = 0; i < 8; i++) send_item(mk(KIND_TICK, 0, 0, 0, 0));
      wait_idle();
      write_reg(CSR_APPROACH_SPEED, 65535);
      write_reg(CSR_STALE_LIMIT, 65535);
      write_reg(CSR_ACCEPTANCE_RADIUS, 8388607);
      write_reg(CSR_MAX_TARGET_DIST, 8388607);
      write_reg(CSR_LOITER_ALTITUDE, CMINV);
      write_reg(CSR_WAYPOINT_RADIUS, 0);
      send_item(mk(KIND_TARGET, 10, 10, 10, 0));
      send_item(mk(KIND_TICK, 0, 0, 0, 0));
      wait_idle();

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 12; ph++) begin
         span = (ph % 3 == 0) ? 8388607 : ((ph % 3 == 1) ? 60000 : 3000);
         write_reg(CSR_APPROACH_SPEED, (ph == 11) ? 65535 : $urandom_range(0, 4000));
         write_reg(CSR_ACCEPTANCE_RADIUS, (ph == 10) ? 0 : $urandom_range(0, 3000));
         write_reg(CSR_LOITER_ALTITUDE, (ph == 9) ? CMAXV : rnd_coord(span));
         write_reg(CSR_WAYPOINT_RADIUS, (ph == 8) ? 8388607 : $urandom_range(0, 6000));
         write_reg(CSR_LAP_TOTAL, (ph == 7) ? 255 : $urandom_range(0, 4));
         write_reg(CSR_WAYPOINT_COUNT, $urandom_range(0, 31));
         write_reg(CSR_STALE_LIMIT, (ph == 6) ? 65535 : $urandom_range(0, 30));
         write_reg(CSR_MAX_TARGET_DIST, (ph == 5) ? 0 : $urandom_range(0, 8388607));
         // Fill every slot in use so no unwritten entry is ever read.
         n_wp = (wp_count > WP_DEPTH) ? WP_DEPTH : wp_count;
         for (int s = 0; s < WP_DEPTH; s++)
            if (s < n_wp || !wp_written[s])
               send_item(mk(KIND_WAYPOINT, rnd_coord(span), rnd_coord(span),
                            rnd_coord(span), s));
         // Hold the result side for a long stretch while items keep coming.
         if (ph == 4) begin
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (STALL_MAX) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < 85; i++) begin
            kind_pick = $urandom_range(0, 9);
            if (kind_pick < 5) it = mk(KIND_TICK, rnd_coord(span), rnd_coord(span),
                                       rnd_coord(span), $urandom_range(0, 15));
            else if (kind_pick < 7) it = mk(KIND_POSITION, rnd_coord(span),
                                            rnd_coord(span), rnd_coord(span), 0);
            else if (kind_pick < 9) it = mk(KIND_TARGET, rnd_coord(span),
                                            rnd_coord(span), rnd_coord(span), 0);
            else it = mk(KIND_WAYPOINT, rnd_coord(span), rnd_coord(span),
                         rnd_coord(span), $urandom_range(0, 15));
            send_item(it);
         end
         wait_idle();
      end

      if (fail_count == 0 && setpoint_q.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
